// ----- rtl/lh_pkg.sv -----
// ----------------------------------------------------------------------------
// lh_pkg
// Shared constants, codes and types of the dual-scale latency histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package lh_pkg;

  // Histogram geometry.
  localparam int unsigned BUCKETS = 2048;
  localparam int unsigned HIST_AW = $clog2(BUCKETS);

  // Field widths.
  localparam int unsigned OP_W     = 2;
  localparam int unsigned SEC_W    = 32;
  localparam int unsigned NSEC_W   = 30;
  localparam int unsigned IDX_W    = 11;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned DELTA_W  = 63;
  localparam int unsigned SLOW_W   = 62;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned WIDTH_W  = 16;

  // A quotient below BUCKETS means the delta is below BUCKETS * width.
  localparam int unsigned DVD_W    = HIST_AW + WIDTH_W;
  localparam int unsigned IDXC_W   = ((HIST_AW > IDX_W) ? HIST_AW : IDX_W) + 1;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [NSEC_W-1:0]  NS_PER_SEC   = 30'd1000000000;
  localparam logic [WIDTH_W-1:0] FINE_RESET   = 16'd1;
  localparam logic [WIDTH_W-1:0] COARSE_RESET = 16'd250;

  typedef enum logic [OP_W-1:0] {
    OP_RECORD = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_RECORDED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_BACKWARDS = 3'd2,
    ST_READ_DONE = 3'd3,
    ST_CLEARED   = 3'd4
  } stat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FINE_BUCKET   = 8'd0,
    REG_COARSE_BUCKET = 8'd1
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_MUL_LO,
    S_MUL_HI,
    S_SUM,
    S_CHECK,
    S_DIV,
    S_RMW_RD,
    S_RMW_WR,
    S_READ,
    S_READ_WAIT,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ----- rtl/lh_ifs.sv -----
// ----------------------------------------------------------------------------
// lh_ifs
// Request, response and configuration channels of the latency histogram.
// ----------------------------------------------------------------------------
`default_nettype none

interface lh_req_if;
  import lh_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [SEC_W-1:0]  start_sec;
  logic [NSEC_W-1:0] start_nsec;
  logic [SEC_W-1:0]  stop_sec;
  logic [NSEC_W-1:0] stop_nsec;
  logic [IDX_W-1:0]  bucket_index;
  logic              pick_coarse;

  modport source (output valid, opcode, start_sec, start_nsec, stop_sec, stop_nsec,
                  bucket_index, pick_coarse, input ready);
  modport sink (input valid, opcode, start_sec, start_nsec, stop_sec, stop_nsec,
                bucket_index, pick_coarse, output ready);
endinterface

interface lh_rsp_if;
  import lh_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [STAT_W-1:0]         status;
  logic signed [DELTA_W-1:0] delta_ns;
  logic [CNT_W-1:0]          bucket_count;
  logic [CNT_W-1:0]          dup_total;
  logic [SLOW_W-1:0]         slowest_ns;

  modport source (output valid, status, delta_ns, bucket_count, dup_total, slowest_ns,
                  input ready);
  modport sink (input valid, status, delta_ns, bucket_count, dup_total, slowest_ns,
                output ready);
endinterface

interface lh_cfg_if;
  import lh_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/dual_scale_latency_histogram_core.sv -----
// ----------------------------------------------------------------------------
// dual_scale_latency_histogram_core
// Latency histogram with a fine and a coarse scale, kept in two RAMs.
// ----------------------------------------------------------------------------
// Flow: a record request with a positive delta goes through the multiply, sum
//   and check states, the bit-serial divider and the read-modify-write before
//   its response; a zero or backward delta skips the divider and the update.
// A read request passes S_READ and S_READ_WAIT; a clear request waits for
//   the sweep that zeroes both RAMs one entry per cycle.
// Throughput: one request at a time; the next is accepted in the cycle after the
//   response is loaded into the output register, even while it waits there.
// Reset: synchronous; the block then sweeps all BUCKETS entries of both RAMs and
//   accepts no request during that sweep; configuration writes are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_scale_latency_histogram_core (
  input logic       clk,
  input logic       rst,
  lh_cfg_if.sink    cfg,
  lh_req_if.sink    req,
  lh_rsp_if.source  rsp
);
  import lh_pkg::*;

  localparam logic [HIST_AW-1:0] SWEEP_LAST = HIST_AW'(BUCKETS - 1);
  localparam logic [DVD_W-1:0]   BUCKETS_V  = DVD_W'(BUCKETS);
  localparam logic [IDXC_W-1:0]  BUCKETS_I  = IDXC_W'(BUCKETS);
  localparam logic [CNT_W-1:0]   CNT_MAX    = '1;

  // Control state.
  fsm_t state, state_next;
  logic div_start;

  // Configuration registers and the derived range limits.
  logic [WIDTH_W-1:0] fine_bkt, coarse_bkt;
  logic [DVD_W-1:0]   lim_f, lim_c;

  // The current request.
  op_t                 op_q;
  logic signed [SEC_W:0]  sdiff;
  logic signed [NSEC_W:0] nsdiff;
  logic [HIST_AW-1:0]  rd_addr;
  logic                rd_ok;
  logic                rd_coarse;
  logic [IDXC_W-1:0]   idx_ext;

  // Delta datapath.
  logic signed [16:0]         mul_a;
  logic signed [47:0]         mul_p;
  logic signed [47:0]         prod_lo, prod_hi;
  logic [63:0]                sum;
  logic [DELTA_W-1:0]         delta;
  logic                       delta_zero;
  logic                       f_ok, c_ok;

  // Running counters.
  logic [CNT_W-1:0]  dup_count;
  logic [SLOW_W-1:0] max_delta;
  stat_t             r_status;
  logic [CNT_W-1:0]  r_count;

  // Clear sweep.
  logic [HIST_AW-1:0] clr_addr;
  logic               sweep_resp;

  // Divider and RAM ports.
  div_stat_t          div_st;
  logic [HIST_AW-1:0] q_f, q_c;
  logic               we_f, we_c;
  logic [HIST_AW-1:0] waddr_f, waddr_c, raddr_f, raddr_c;
  logic [CNT_W-1:0]   wdata_f, wdata_c, rdata_f, rdata_c;

  // Output register.
  logic rsp_valid;
  logic rsp_load;
  logic accept;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fine_bkt   <= FINE_RESET;
      coarse_bkt <= COARSE_RESET;
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_FINE_BUCKET:   fine_bkt   <= cfg.data[WIDTH_W-1:0];
        REG_COARSE_BUCKET: coarse_bkt <= cfg.data[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  // The quotient is below BUCKETS exactly when the delta is below
  // BUCKETS * width. A zero width gives a zero limit, so nothing is counted.
  always_ff @(posedge clk) begin
    lim_f <= BUCKETS_V * {{HIST_AW{1'b0}}, fine_bkt};
    lim_c <= BUCKETS_V * {{HIST_AW{1'b0}}, coarse_bkt};
  end

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign rsp_load  = (state == S_DONE) && (!rsp_valid || rsp.ready);

  // Next state. Opcode 3 is accepted and dropped without a response.
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      S_SWEEP: begin
        if (clr_addr == SWEEP_LAST) begin
          state_next = sweep_resp ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.valid) begin
          case (op_t'(req.opcode))
            OP_RECORD: state_next = S_MUL_LO;
            OP_READ:   state_next = S_READ;
            OP_CLEAR:  state_next = S_SWEEP;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_MUL_LO: state_next = S_MUL_HI;
      S_MUL_HI: state_next = S_SUM;
      S_SUM:    state_next = S_CHECK;
      S_CHECK: begin
        if (delta[DELTA_W-1] || delta_zero) begin
          state_next = S_DONE;
        end else begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          state_next = S_RMW_RD;
        end
      end
      S_RMW_RD:    state_next = S_RMW_WR;
      S_RMW_WR:    state_next = S_DONE;
      S_READ:      state_next = S_READ_WAIT;
      S_READ_WAIT: state_next = S_DONE;
      S_DONE: begin
        if (!rsp_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  // Capture the request. The second differences are formed right away; the
  // read index is range checked against BUCKETS.
  assign idx_ext = IDXC_W'(req.bucket_index);

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= op_t'(req.opcode);
      sdiff     <= $signed({1'b0, req.stop_sec}) - $signed({1'b0, req.start_sec});
      nsdiff    <= $signed({1'b0, req.stop_nsec}) - $signed({1'b0, req.start_nsec});
      rd_addr   <= idx_ext[HIST_AW-1:0];
      rd_ok     <= (idx_ext < BUCKETS_I);
      rd_coarse <= req.pick_coarse;
    end
  end

  // The seconds difference is 33 bits; it is multiplied by one billion in
  // two halves through one 17 by 31 bit multiplier, then summed.
  always_comb begin
    if (state == S_MUL_HI) begin
      mul_a = sdiff[SEC_W:16];
    end else begin
      mul_a = $signed({1'b0, sdiff[15:0]});
    end
  end

  assign mul_p = mul_a * $signed({1'b0, NS_PER_SEC});

  assign sum = {prod_hi, 16'h0000} + {16'h0000, prod_lo}
             + {{(64 - NSEC_W - 1){nsdiff[NSEC_W]}}, nsdiff};

  assign delta_zero = (delta == '0);

  always_ff @(posedge clk) begin
    if (state == S_MUL_LO) begin
      prod_lo <= mul_p;
    end
    if (state == S_MUL_HI) begin
      prod_hi <= mul_p;
    end
    if (state == S_SUM) begin
      // The true delta always fits in 63 bits, so dropping the top bit is exact.
      delta <= sum[DELTA_W-1:0];
    end
    if (state == S_CHECK) begin
      f_ok <= (delta[SLOW_W-1:DVD_W] == '0) && (delta[DVD_W-1:0] < lim_f);
      c_ok <= (delta[SLOW_W-1:DVD_W] == '0) && (delta[DVD_W-1:0] < lim_c);
    end
  end

  // Counters, response status and the captured bucket count.
  always_ff @(posedge clk) begin
    if (rst) begin
      dup_count  <= '0;
      max_delta  <= '0;
      sweep_resp <= 1'b0;
      clr_addr   <= '0;
    end else begin
      if (state == S_SWEEP) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (accept && (op_t'(req.opcode) == OP_CLEAR)) begin
        dup_count  <= '0;
        max_delta  <= '0;
        sweep_resp <= 1'b1;
        clr_addr   <= '0;
      end
      if (state == S_CHECK && !delta[DELTA_W-1]) begin
        if (delta_zero) begin
          if (dup_count != CNT_MAX) begin
            dup_count <= dup_count + 1'b1;
          end
        end else if (delta[SLOW_W-1:0] > max_delta) begin
          max_delta <= delta[SLOW_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_count <= '0;
      case (op_t'(req.opcode))
        OP_READ:  r_status <= ST_READ_DONE;
        OP_CLEAR: r_status <= ST_CLEARED;
        default:  r_status <= ST_RECORDED;
      endcase
    end
    if (state == S_CHECK) begin
      if (delta[DELTA_W-1]) begin
        r_status <= ST_BACKWARDS;
      end else if (delta_zero) begin
        r_status <= ST_DUPLICATE;
      end else begin
        r_status <= ST_RECORDED;
      end
    end
    if (state == S_READ_WAIT) begin
      if (!rd_ok) begin
        r_count <= '0;
      end else if (rd_coarse) begin
        r_count <= rdata_c;
      end else begin
        r_count <= rdata_f;
      end
    end
  end

  // Both bucket indexes come out of one two-lane divider.
  lh_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .dvd_f (delta[DVD_W-1:0]),
    .dvd_c (delta[DVD_W-1:0]),
    .dsr_f (fine_bkt),
    .dsr_c (coarse_bkt),
    .stat  (div_st),
    .q_f   (q_f),
    .q_c   (q_c)
  );

  // Read-modify-write: the bucket is read in S_RMW_RD and written back in
  // S_RMW_WR. Requests are handled one at a time, so no two accesses to the
  // same entry overlap. A full counter is left alone.
  assign raddr_f = (state == S_READ) ? rd_addr : q_f;
  assign raddr_c = (state == S_READ) ? rd_addr : q_c;

  always_comb begin
    if (state == S_SWEEP) begin
      we_f    = 1'b1;
      we_c    = 1'b1;
      waddr_f = clr_addr;
      waddr_c = clr_addr;
      wdata_f = '0;
      wdata_c = '0;
    end else begin
      we_f    = (state == S_RMW_WR) && f_ok && (rdata_f != CNT_MAX);
      we_c    = (state == S_RMW_WR) && c_ok && (rdata_c != CNT_MAX);
      waddr_f = q_f;
      waddr_c = q_c;
      wdata_f = rdata_f + 1'b1;
      wdata_c = rdata_c + 1'b1;
    end
  end

  lh_ram #(.DEPTH(BUCKETS), .WIDTH(CNT_W)) u_fine_ram (
    .clk   (clk),
    .we    (we_f),
    .waddr (waddr_f),
    .wdata (wdata_f),
    .raddr (raddr_f),
    .rdata (rdata_f)
  );

  lh_ram #(.DEPTH(BUCKETS), .WIDTH(CNT_W)) u_coarse_ram (
    .clk   (clk),
    .we    (we_c),
    .waddr (waddr_c),
    .wdata (wdata_c),
    .raddr (raddr_c),
    .rdata (rdata_c)
  );

  // Output register; it holds a response while the next request is worked on.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.status       <= r_status;
      rsp.delta_ns     <= (op_q == OP_RECORD) ? $signed(delta) : '0;
      rsp.bucket_count <= r_count;
      rsp.dup_total    <= dup_count;
      rsp.slowest_ns   <= max_delta;
    end
  end

  assign rsp.valid = rsp_valid;

  // A new response only ever appears right after the response state.
  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_DONE))
    else $error("response raised outside the response state");

  // The divider finishes only while the controller waits for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> (state == S_DIV))
    else $error("divider finished outside the divide state");

  // No request is taken while the divider still works.
  a_ready_div_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !div_st.busy)
    else $error("request accepted while divider busy");

  // An increment never wraps a fine bucket counter to zero.
  a_no_wrap_f: assert property (@(posedge clk) disable iff (rst)
    (we_f && (state != S_SWEEP)) |-> (wdata_f != '0))
    else $error("fine bucket counter wrapped");

  // The sweep walks the RAM one entry per cycle once reset has been released.
  a_sweep_step: assert property (@(posedge clk) disable iff (rst)
    (!rst && (state == S_SWEEP) && (clr_addr != SWEEP_LAST)) |=>
      ((state == S_SWEEP) && (clr_addr == $past(clr_addr) + 1'b1)))
    else $error("clear sweep skipped an entry");

endmodule

`default_nettype wire

// ----- rtl/lh_ram.sv -----
// ----------------------------------------------------------------------------
// lh_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module lh_ram #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/lh_div.sv -----
// ----------------------------------------------------------------------------
// lh_div
// Two-lane restoring divider, one quotient bit per lane and cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lh_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lh_pkg::DVD_W-1:0]     dvd_f,
  input  logic [lh_pkg::DVD_W-1:0]     dvd_c,
  input  logic [lh_pkg::WIDTH_W-1:0]   dsr_f,
  input  logic [lh_pkg::WIDTH_W-1:0]   dsr_c,
  output lh_pkg::div_stat_t            stat,
  output logic [lh_pkg::HIST_AW-1:0]   q_f,
  output logic [lh_pkg::HIST_AW-1:0]   q_c
);
  import lh_pkg::*;

  localparam int unsigned CW = $clog2(HIST_AW + 1);

  // The quotient is only used when it fits in HIST_AW bits; then the upper
  // WIDTH_W bits already form a remainder below the divisor.
  function automatic logic [WIDTH_W:0] div_step(input logic [WIDTH_W-1:0] rem,
                                                input logic                nbit,
                                                input logic [WIDTH_W-1:0] dsr);
    logic [WIDTH_W:0] trial;
    logic [WIDTH_W:0] diff;
    trial = {rem, nbit};
    diff  = trial - {1'b0, dsr};
    if (trial >= {1'b0, dsr}) begin
      div_step = {1'b1, diff[WIDTH_W-1:0]};
    end else begin
      div_step = {1'b0, trial[WIDTH_W-1:0]};
    end
  endfunction

  logic [WIDTH_W-1:0] rem_f, rem_c;
  logic [HIST_AW-1:0] sh_f, sh_c;
  logic [CW-1:0]      cnt;
  logic               busy, done;
  logic [WIDTH_W:0]   step_f, step_c;

  assign step_f = div_step(rem_f, sh_f[HIST_AW-1], dsr_f);
  assign step_c = div_step(rem_c, sh_c[HIST_AW-1], dsr_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(HIST_AW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_f <= dvd_f[DVD_W-1:HIST_AW];
      rem_c <= dvd_c[DVD_W-1:HIST_AW];
      sh_f  <= dvd_f[HIST_AW-1:0];
      sh_c  <= dvd_c[HIST_AW-1:0];
    end else if (busy) begin
      rem_f <= step_f[WIDTH_W-1:0];
      rem_c <= step_c[WIDTH_W-1:0];
      sh_f  <= {sh_f[HIST_AW-2:0], step_f[WIDTH_W]};
      sh_c  <= {sh_c[HIST_AW-2:0], step_c[WIDTH_W]};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign q_f       = sh_f;
  assign q_c       = sh_c;

endmodule

`default_nettype wire
